// ----- rtl/psc_pkg.sv -----
// Shared types, codes and helpers of the position seek controller.
// Used by psc_regs and position_seek_controller_top; depends on nothing.
package psc_pkg;

    // Item function codes
    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_SEEK      = 3'd1;
    localparam logic [2:0] FUNC_HOLD_VAL  = 3'd2;
    localparam logic [2:0] FUNC_HOLD_HERE = 3'd3;
    localparam logic [2:0] FUNC_RUN       = 3'd4;
    localparam logic [2:0] FUNC_SET_POS   = 3'd5;

    // Register map, index = paddr[4:2]
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] REG_SCALE       = 3'd0;
    localparam logic [2:0] REG_LOW_STOP    = 3'd1;
    localparam logic [2:0] REG_HIGH_STOP   = 3'd2;
    localparam logic [2:0] REG_SETTLE      = 3'd3;
    localparam logic [2:0] REG_UP_GAIN     = 3'd4;
    localparam logic [2:0] REG_DOWN_GAIN   = 3'd5;
    localparam logic [2:0] REG_UP_BUTTON   = 3'd6;
    localparam logic [2:0] REG_DOWN_BUTTON = 3'd7;

    // Drive percent limits
    localparam logic signed [7:0] PCT_MAX = 8'sd100;
    localparam logic signed [7:0] PCT_MIN = -8'sd100;

    typedef struct packed {
        logic signed [15:0] scale_q8;
        logic signed [23:0] low_stop;
        logic signed [23:0] high_stop;
        logic        [22:0] settle_range;
        logic        [15:0] up_gain_q8;
        logic        [15:0] down_gain_q8;
        logic signed [7:0]  up_button_speed;
        logic signed [7:0]  down_button_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        scale_q8:          16'sd256,
        low_stop:          24'sd0,
        high_stop:         24'sd0,
        settle_range:      23'd0,
        up_gain_q8:        16'd256,
        down_gain_q8:      16'd256,
        up_button_speed:   8'sd100,
        down_button_speed: -8'sd100
    };

    // Clamp a drive value to +/-100
    function automatic logic signed [7:0] sat_pct(input logic signed [7:0] v);
        if (v > PCT_MAX) begin
            return PCT_MAX;
        end else if (v < PCT_MIN) begin
            return PCT_MIN;
        end
        return v;
    endfunction

    // Clamp a 34-bit value to the 32-bit signed offset range
    function automatic logic signed [31:0] sat_off(input logic signed [33:0] v);
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
            return v[31:0];
        end else if (v[33]) begin
            return 32'sh8000_0000;
        end
        return 32'sh7FFF_FFFF;
    endfunction

endpackage

// ----- rtl/psc_regs.sv -----
// APB configuration registers of the position seek controller.
// Depends on psc_pkg for the register map, reset values and cfg_t.
module psc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psc_pkg::APB_AW-1:0]    paddr,
    input  logic [psc_pkg::APB_DW-1:0]    pwdata,
    output logic [psc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output psc_pkg::cfg_t                 cfg
);
    import psc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SCALE:       cfg_reg.scale_q8          <= pwdata[15:0];
                REG_LOW_STOP:    cfg_reg.low_stop          <= pwdata[23:0];
                REG_HIGH_STOP:   cfg_reg.high_stop         <= pwdata[23:0];
                REG_SETTLE:      cfg_reg.settle_range      <= pwdata[22:0];
                REG_UP_GAIN:     cfg_reg.up_gain_q8        <= pwdata[15:0];
                REG_DOWN_GAIN:   cfg_reg.down_gain_q8      <= pwdata[15:0];
                REG_UP_BUTTON:   cfg_reg.up_button_speed   <= pwdata[7:0];
                REG_DOWN_BUTTON: cfg_reg.down_button_speed <= pwdata[7:0];
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Read back, raw register bits
    always_comb begin
        unique case (reg_idx)
            REG_SCALE:       prdata = {16'd0, cfg_reg.scale_q8};
            REG_LOW_STOP:    prdata = {8'd0, cfg_reg.low_stop};
            REG_HIGH_STOP:   prdata = {8'd0, cfg_reg.high_stop};
            REG_SETTLE:      prdata = {9'd0, cfg_reg.settle_range};
            REG_UP_GAIN:     prdata = {16'd0, cfg_reg.up_gain_q8};
            REG_DOWN_GAIN:   prdata = {16'd0, cfg_reg.down_gain_q8};
            REG_UP_BUTTON:   prdata = {24'd0, cfg_reg.up_button_speed};
            REG_DOWN_BUTTON: prdata = {24'd0, cfg_reg.down_button_speed};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/psc_mul.sv -----
// Shared signed multiplier with a registered product.
// Used for both the encoder scale and the seek gain; no dependencies.
module psc_mul #(
    parameter int A_W = 25,
    parameter int B_W = 17
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  prod
);
    logic signed [A_W+B_W-1:0] prod_reg;

    // One product per enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/position_seek_controller_top.sv -----
// Position seek controller: top level, sequencer and datapath.
// Depends on psc_pkg, psc_regs and psc_mul.

// A tick item (func 0) steps from its transfer on the s_ channel through the
// multiply, sum, low stop, high stop, error, gain, speed and done states until its
// result is valid on m_. The block returns to idle at that same edge and takes no
// new item before then. The step sequence is set by a single shared multiplier,
// used once for the encoder scale and once for the seek gain, with the stop
// re-zeroing done as separate compare and add steps between them. A command item
// goes straight to the done state after its transfer. s_ready is high only while
// idle. A finished result sits in the m_ output register, so the next item can be
// taken while it waits. Registers lie at byte address 4*i on the APB port and may be
// written only while the block is idle with no result outstanding. POS_WIDTH sets
// the width of the stored position and of m_position_now (12 to 32).
module position_seek_controller_top #(
    parameter int POS_WIDTH = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psc_pkg::APB_AW-1:0]         paddr,
    input  logic [psc_pkg::APB_DW-1:0]         pwdata,
    output logic [psc_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_func,
    input  logic signed [23:0]                 s_rotation,
    input  logic signed [23:0]                 s_value,
    input  logic                               s_up_pressed,
    input  logic                               s_down_pressed,
    input  logic                               s_manual_enable,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [7:0]                  m_drive_speed,
    output logic signed [POS_WIDTH-1:0]        m_position_now,
    output logic                               m_is_seeking,
    output logic                               m_is_holding
);
    import psc_pkg::*;

    // Widths: target, error, multiplier operands
    localparam int TW = (POS_WIDTH > 24) ? POS_WIDTH : 24;
    localparam int EW = TW + 1;
    localparam int MA = (EW > 25) ? EW : 25;
    localparam int MB = 17;
    localparam int PW = MA + MB;

    localparam logic signed [33:0] POS_MAX = (34'sd1 <<< (POS_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] POS_MIN = -POS_MAX - 34'sd1;
    localparam logic signed [PW-1:0] SEEK_MAX = PW'(100);
    localparam logic signed [PW-1:0] SEEK_MIN = -SEEK_MAX;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_LOW   = 4'd3;
    localparam logic [3:0] S_LOWP  = 4'd4;
    localparam logic [3:0] S_HIGH  = 4'd5;
    localparam logic [3:0] S_HIGHP = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_GAIN  = 4'd8;
    localparam logic [3:0] S_SPEED = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [33:0] v);
        if (v > POS_MAX) begin
            return POS_MAX[POS_WIDTH-1:0];
        end else if (v < POS_MIN) begin
            return POS_MIN[POS_WIDTH-1:0];
        end
        return v[POS_WIDTH-1:0];
    endfunction

    cfg_t cfg;

    logic [3:0]                  state_reg, state_next;
    // controller state
    logic signed [23:0]          base_reg;
    logic signed [31:0]          offset_reg;
    logic signed [TW-1:0]        target_reg;
    logic signed [POS_WIDTH-1:0] last_pos_reg;
    logic signed [7:0]           ovr_speed_reg;
    logic                        seek_reg, hold_reg, ovr_reg;
    // tick working registers
    logic signed [23:0]          rot_reg;
    logic                        up_reg, down_reg, man_en_reg;
    logic signed [33:0]          scaled_reg, pos_reg;
    logic signed [EW-1:0]        err_reg;
    logic signed [7:0]           speed_reg;
    // output register
    logic                        m_valid_reg;
    logic signed [7:0]           m_speed_reg;
    logic signed [POS_WIDTH-1:0] m_pos_reg;
    logic                        m_seek_reg, m_hold_reg;

    logic                        s_fire, out_free, stops_differ;
    logic                        mul_en;
    logic signed [MA-1:0]        mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        seek_raw;
    logic signed [7:0]           seek_pct, tick_speed, run_pct;
    logic signed [33:0]          scaled_next, stop_off_src;
    logic signed [POS_WIDTH-1:0] pos_sat;
    logic [EW:0]                 err_mag;
    logic                        seek_after, hold_after, ovr_after;

    psc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psc_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_ready      = (state_reg == S_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign stops_differ = (cfg.low_stop != cfg.high_stop);

    // Multiplier operand select: encoder scale, then seek gain
    always_comb begin
        mul_en = (state_reg == S_MUL) || (state_reg == S_GAIN);
        if (state_reg == S_GAIN) begin
            mul_a = MA'(err_reg);
            mul_b = (err_reg > 0) ? signed'({1'b0, cfg.up_gain_q8})
                                  : signed'({1'b0, cfg.down_gain_q8});
        end else begin
            mul_a = MA'(25'(rot_reg) - 25'(base_reg));
            mul_b = MB'(cfg.scale_q8);
        end
    end

    // Scaled rotation (sign kept by taking the top bits), stop source, saturated position
    assign scaled_next  = prod[41:8];
    assign stop_off_src = (state_reg == S_LOW) ? 34'(cfg.low_stop) : 34'(cfg.high_stop);
    assign pos_sat      = sat_pos(pos_reg);

    // Seek speed, settle test and run command speed
    assign seek_raw = prod >>> 8;
    assign seek_pct = (seek_raw > SEEK_MAX) ? PCT_MAX :
                      (seek_raw < SEEK_MIN) ? PCT_MIN : seek_raw[7:0];
    assign err_mag  = err_reg[EW-1] ? -(EW+1)'(err_reg) : (EW+1)'(err_reg);
    assign run_pct  = (s_value > 24'sd100)  ? PCT_MAX :
                      (s_value < -24'sd100) ? PCT_MIN : s_value[7:0];

    // Speed priority, lowest first: seek, then override, then manual buttons (up last)
    always_comb begin
        tick_speed = '0;
        seek_after = seek_reg;
        hold_after = hold_reg;
        ovr_after  = ovr_reg;
        if (seek_reg) begin
            if (!hold_reg && (err_mag < (EW+1)'(cfg.settle_range))) begin
                seek_after = 1'b0;
            end
            tick_speed = seek_pct;
        end
        if (ovr_reg) begin
            tick_speed = ovr_speed_reg;
        end
        if (man_en_reg) begin
            if (down_reg) begin
                seek_after = 1'b0;
                hold_after = 1'b0;
                ovr_after  = 1'b0;
                tick_speed = cfg.down_button_speed;
            end
            if (up_reg) begin
                seek_after = 1'b0;
                hold_after = 1'b0;
                ovr_after  = 1'b0;
                tick_speed = cfg.up_button_speed;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_func == FUNC_TICK) ? S_MUL : S_DONE;
                end
            end
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_LOW;
            S_LOW:   state_next = S_LOWP;
            S_LOWP:  state_next = S_HIGH;
            S_HIGH:  state_next = S_HIGHP;
            S_HIGHP: state_next = S_ERR;
            S_ERR:   state_next = S_GAIN;
            S_GAIN:  state_next = S_SPEED;
            S_SPEED: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Controller state: commands on transfer, tick updates in their steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            offset_reg    <= '0;
            target_reg    <= '0;
            last_pos_reg  <= '0;
            ovr_speed_reg <= '0;
            seek_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            ovr_reg       <= 1'b0;
        end else begin
            if (s_fire) begin
                case (s_func)
                    FUNC_SEEK: begin
                        target_reg <= TW'(s_value);
                        seek_reg   <= 1'b1;
                        hold_reg   <= 1'b0;
                    end
                    FUNC_HOLD_VAL: begin
                        target_reg <= TW'(s_value);
                        seek_reg   <= 1'b1;
                        hold_reg   <= 1'b1;
                        ovr_reg    <= 1'b0;
                    end
                    FUNC_HOLD_HERE: begin
                        target_reg <= TW'(last_pos_reg);
                        seek_reg   <= 1'b1;
                        hold_reg   <= 1'b1;
                        ovr_reg    <= 1'b0;
                    end
                    FUNC_RUN: begin
                        ovr_speed_reg <= run_pct;
                        ovr_reg       <= 1'b1;
                        seek_reg      <= 1'b0;
                    end
                    FUNC_SET_POS: begin
                        base_reg     <= s_rotation;
                        offset_reg   <= 32'(s_value);
                        last_pos_reg <= sat_pos(34'(s_value));
                    end
                    default: begin
                        // tick and unused codes leave the state alone here
                    end
                endcase
            end
            // Re-zero the offset on a passed stop
            if ((state_reg == S_LOW) && stops_differ && (pos_reg < 34'(cfg.low_stop))) begin
                offset_reg <= sat_off(stop_off_src - scaled_reg);
            end
            if ((state_reg == S_HIGH) && stops_differ && (pos_reg > 34'(cfg.high_stop))) begin
                offset_reg <= sat_off(stop_off_src - scaled_reg);
            end
            if (state_reg == S_ERR) begin
                last_pos_reg <= pos_sat;
            end
            if (state_reg == S_SPEED) begin
                seek_reg <= seek_after;
                hold_reg <= hold_after;
                ovr_reg  <= ovr_after;
            end
        end
    end

    // Tick working registers and result speed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rot_reg    <= s_rotation;
            up_reg     <= s_up_pressed;
            down_reg   <= s_down_pressed;
            man_en_reg <= s_manual_enable;
            speed_reg  <= '0;
        end
        unique case (state_reg)
            S_SUM: begin
                scaled_reg <= scaled_next;
                pos_reg    <= scaled_next + 34'(offset_reg);
            end
            S_LOWP, S_HIGHP: pos_reg <= scaled_reg + 34'(offset_reg);
            S_ERR:   err_reg   <= EW'(target_reg) - EW'(pos_sat);
            S_SPEED: speed_reg <= sat_pct(tick_speed);
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_speed_reg <= speed_reg;
            m_pos_reg   <= last_pos_reg;
            m_seek_reg  <= seek_reg;
            m_hold_reg  <= hold_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_speed  = m_speed_reg;
    assign m_position_now = m_pos_reg;
    assign m_is_seeking   = m_seek_reg;
    assign m_is_holding   = m_hold_reg;

    // Checks
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_func == FUNC_TICK) |=> (state_reg == S_MUL))
        else $error("tick transfer did not start the multiply step");

    a_cmd_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_func != FUNC_TICK) |=> (state_reg == S_DONE))
        else $error("command did not go straight to result");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && m_valid_reg && !m_ready |=> (state_reg == S_DONE))
        else $error("result left before the output register was free");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_drive_speed <= PCT_MAX) && (m_drive_speed >= PCT_MIN)))
        else $error("drive speed outside +/-100");

endmodule
